// ===== rtl/pbshd_pkg.sv =====
`default_nettype none

package pbshd_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned CountW  = 9;
  localparam int unsigned PosW    = 17;
  localparam int unsigned SumW    = 24;
  localparam int unsigned PortW   = 8;
  localparam int unsigned StepW   = 5;

  localparam logic [PosW-1:0]  POS_MAX   = '1;
  localparam logic [StepW-1:0] LAST_STEP = StepW'(SumW - 1);

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_WINDOW_OFFSET = 2'd0;
  localparam logic [IdxW-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [IdxW-1:0] REG_PORT_COUNT    = 2'd2;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic accept;   // take one byte into position and sum
    logic finish;   // packet ends: latch result inputs, clear counters
    logic step;     // one bit of the remainder loop
    logic publish;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic last;      // last-byte mark of the offered word
    logic div_done;  // remainder loop on its final bit
    logic out_free;  // output register empty or being taken
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/pbshd_ctrl.sv =====
`default_nettype none

module pbshd_ctrl
  import pbshd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.last) begin
          cmd.finish = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.div_done) begin
          state_next = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pbshd_dpath.sv =====
`default_nettype none

module pbshd_dpath
  import pbshd_pkg::*;
#(
  parameter int unsigned MAX_PORTS = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IdxW-1:0]  cfg_index,
  input  wire logic [CfgW-1:0]  cfg_data,
  input  wire logic [DataW-1:0] data_byte,
  input  wire logic             last_byte,
  input  wire cmd_t             cmd,
  output status_t               status,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PortW-1:0]      port_index,
  output logic                  too_short
);

  localparam logic [CountW-1:0] MaxN = CountW'(MAX_PORTS);

  logic [CfgW-1:0]   win_offset;
  logic [CfgW-1:0]   win_length;
  logic [PosW-1:0]   win_end;
  logic [CountW-1:0] port_count;

  logic [PosW-1:0]   pos;
  logic [SumW-1:0]   sum;

  logic [SumW-1:0]   dividend;
  logic [PortW-1:0]  rem;
  logic [StepW-1:0]  step_cnt;
  logic [CountW-1:0] n_q;
  logic              pow2_q;
  logic [2:0]        hash_q;
  logic              short_q;

  logic              in_win;
  logic [SumW-1:0]   sum_final;
  logic [PosW-1:0]   pos_inc;
  logic              short_final;
  logic [CountW-1:0] n_eff;
  logic              n_pow2;
  logic [CountW-1:0] trial;
  logic [2:0]        mask;

  // Config registers; window end tracks offset + length
  always_ff @(posedge clk) begin
    if (rst) begin
      win_offset <= '0;
      win_length <= CfgW'(1);
      win_end    <= PosW'(1);
      port_count <= CountW'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_OFFSET: begin
          win_offset <= cfg_data;
          win_end    <= {1'b0, cfg_data} + {1'b0, win_length};
        end
        REG_WINDOW_LENGTH: begin
          win_length <= cfg_data;
          win_end    <= {1'b0, win_offset} + {1'b0, cfg_data};
        end
        REG_PORT_COUNT: begin
          port_count <= cfg_data[CountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_win      = (pos >= {1'b0, win_offset}) && (pos < win_end);
    sum_final   = sum + (in_win ? {{(SumW-DataW){1'b0}}, data_byte} : '0);
    pos_inc     = (pos == POS_MAX) ? pos : pos + PosW'(1);
    short_final = pos_inc < win_end;
    if (port_count == '0) begin
      n_eff = CountW'(1);
    end else if (port_count > MaxN) begin
      n_eff = MaxN;
    end else begin
      n_eff = port_count;
    end
    n_pow2 = (n_eff == CountW'(2)) || (n_eff == CountW'(4)) || (n_eff == CountW'(8));
    mask   = n_eff[2:0] - 3'd1;
    trial  = {rem, dividend[SumW-1]};
  end

  // Position counter and running window sum
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
    end else if (cmd.finish) begin
      pos <= '0;
      sum <= '0;
    end else if (cmd.accept) begin
      pos <= pos_inc;
      sum <= sum_final;
    end
  end

  // Restoring remainder loop, one dividend bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dividend <= sum_final;
      rem      <= '0;
      step_cnt <= '0;
      n_q      <= n_eff;
      pow2_q   <= n_pow2;
      hash_q   <= (sum_final[2:0] ^ sum_final[6:4]) & mask;
      short_q  <= short_final;
    end else if (cmd.step) begin
      dividend <= {dividend[SumW-2:0], 1'b0};
      step_cnt <= step_cnt + StepW'(1);
      if (trial >= n_q) begin
        rem <= PortW'(trial - n_q);
      end else begin
        rem <= trial[PortW-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      too_short <= short_q;
      if (short_q) begin
        port_index <= '0;
      end else if (pow2_q) begin
        port_index <= {{(PortW-3){1'b0}}, hash_q};
      end else begin
        port_index <= rem;
      end
    end
  end

  always_comb begin
    status.last     = last_byte;
    status.div_done = (step_cnt == LAST_STEP);
    status.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/packet_byte_sum_hash_demux.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_ready    data_byte[7:0], last_byte
// out       source     out_valid/out_ready  port_index[7:0], too_short
// cfg       sink       cfg_write            cfg_index[1:0], cfg_data[15:0]
//
// Bytes that are not last are taken one per cycle. A last byte starts the
// remainder loop, one bit of the window sum per step over all 24 bits, then
// the output register loads, and in_ready stays low until that load.
// The output register frees the input side: bytes of the next packet stream
// while a result waits; only the next last byte's publish waits for out_ready.
// Reset (rst, synchronous) clears counters, drops out_valid, restores config.

module packet_byte_sum_hash_demux
  import pbshd_pkg::*;
#(
  parameter int unsigned MAX_PORTS = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration write port
  input  wire logic             cfg_write,
  input  wire logic [IdxW-1:0]  cfg_index,
  input  wire logic [CfgW-1:0]  cfg_data,
  // packet byte words
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [DataW-1:0] data_byte,
  input  wire logic             last_byte,
  // port choice words
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PortW-1:0]      port_index,
  output logic                  too_short
);

  cmd_t    cmd;
  status_t status;

  // Sequencer: accumulate bytes, run the remainder loop, publish
  pbshd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Counters, window sum, divider and output register
  pbshd_dpath #(
    .MAX_PORTS (MAX_PORTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .port_index (port_index),
    .too_short  (too_short)
  );

endmodule

`default_nettype wire

// ===== rtl/pbshd_checker.sv =====
`default_nettype none

module pbshd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       last_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] port_index,
  input wire logic       too_short
);

  // Hold a waiting result word unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(port_index) && $stable(too_short))
    else $error("result word changed while stalled");

  // A short packet always maps to port zero
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_short |-> port_index == 8'd0)
    else $error("short packet with nonzero port");

  // Drop any result on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word survived reset");

  // The remainder loop blocks input right after a last byte
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> !in_ready ##1 !in_ready)
    else $error("input taken during remainder loop");

endmodule

bind packet_byte_sum_hash_demux pbshd_checker u_pbshd_checker (.*);

`default_nettype wire

// ===== verif/demux_port_checker.sv =====
`timescale 1ns / 100ps

module demux_port_checker
  import pbshd_pkg::*;
#(
  parameter int unsigned MAX_PORTS = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IdxW-1:0]  cfg_index,
  input  wire logic [CfgW-1:0]  cfg_data,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire logic [DataW-1:0] data_byte,
  input  wire logic             last_byte,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire logic [PortW-1:0] port_index,
  input  wire logic             too_short,
  output int                    error_count,
  output int                    words_due,
  output int                    words_checked
);

  typedef struct packed {
    logic [PortW-1:0] port;
    logic             short_pkt;
  } port_word_t;

  // Shadow copy of the registers and the per-packet state
  logic [CfgW-1:0]   win_offset;
  logic [CfgW-1:0]   win_length;
  logic [CountW-1:0] port_total;
  logic [PosW-1:0]   byte_pos;
  logic [PosW-1:0]   win_end;
  logic [SumW-1:0]   win_sum;

  port_word_t  ports_due[$];
  port_word_t  predicted;
  port_word_t  oldest;
  int unsigned spread;
  int unsigned hashed;
  int          errors;
  int          checked;

  always @(posedge clk) begin
    if (rst) begin
      win_offset = '0;
      win_length = CfgW'(1);
      port_total = CountW'(1);
      byte_pos   = '0;
      win_sum    = '0;
      ports_due.delete();
      errors     = 0;
      checked    = 0;
    end else begin
      // Compare first: a result can never come out at the edge of its own last byte
      if (out_valid && out_ready) begin
        if (ports_due.size() == 0) begin
          errors++;
          $display("%0t: port word %0d (too_short %0b) with none expected",
                   $time, port_index, too_short);
        end else begin
          oldest = ports_due.pop_front();
          checked++;
          if (port_index !== oldest.port) begin
            errors++;
            $display("%0t: port_index expected %0d, got %0d", $time, oldest.port, port_index);
          end
          if (too_short !== oldest.short_pkt) begin
            errors++;
            $display("%0t: too_short expected %0b, got %0b", $time, oldest.short_pkt,
                     too_short);
          end
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_OFFSET: win_offset = cfg_data;
          REG_WINDOW_LENGTH: win_length = cfg_data;
          REG_PORT_COUNT:    port_total = cfg_data[CountW-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        win_end = PosW'(win_offset) + PosW'(win_length);
        if (byte_pos >= PosW'(win_offset) && byte_pos < win_end) begin
          win_sum = win_sum + SumW'(data_byte);
        end
        if (byte_pos != POS_MAX) begin
          byte_pos = byte_pos + PosW'(1);
        end
        if (last_byte) begin
          if (byte_pos < win_end) begin
            predicted.port      = '0;
            predicted.short_pkt = 1'b1;
          end else begin
            // Zero ports act as one; counts past the maximum saturate
            spread = 32'(port_total);
            if (spread == 0) spread = 1;
            if (spread > MAX_PORTS) spread = MAX_PORTS;
            hashed = 32'(win_sum);
            if (spread == 2 || spread == 4 || spread == 8) begin
              hashed = (hashed ^ (hashed >> 4)) & (spread - 1);
            end else begin
              hashed = hashed % spread;
            end
            predicted.port      = PortW'(hashed);
            predicted.short_pkt = 1'b0;
          end
          ports_due.push_back(predicted);
          byte_pos = '0;
          win_sum  = '0;
        end
      end
    end
    error_count   <= errors;
    words_due     <= ports_due.size();
    words_checked <= checked;
  end

endmodule

// ===== verif/tb_packet_byte_sum_hash_demux.sv =====
`timescale 1ns / 100ps

module tb_packet_byte_sum_hash_demux;
  import pbshd_pkg::*;

  localparam int unsigned     MAX_PORTS      = 256;
  // Index past the register list: the block must drop writes to it
  localparam logic [IdxW-1:0] REG_UNUSED     = 2'd3;
  // Covers the remainder loop plus output load; leave margin on top
  localparam int              SETTLE_CYCLES  = 40;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              RANDOM_PHASES  = 12;
  localparam int              PHASE_BYTES    = 112;
  localparam int              FILL_RANDOM    = -1;

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             cfg_write  = 1'b0;
  logic [IdxW-1:0]  cfg_index  = '0;
  logic [CfgW-1:0]  cfg_data   = '0;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic [DataW-1:0] data_byte  = '0;
  logic             last_byte  = 1'b0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic [PortW-1:0] port_index;
  logic             too_short;

  int error_count;
  int words_due;
  int words_checked;

  // Idle mix: percent of cycles the sender idles, percent of cycles the receiver stalls
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  int bytes_sent    = 0;
  int packets_sent  = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  always #5 clk = ~clk;

  packet_byte_sum_hash_demux #(
    .MAX_PORTS(MAX_PORTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .port_index(port_index),
    .too_short (too_short)
  );

  demux_port_checker #(
    .MAX_PORTS(MAX_PORTS)
  ) port_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .port_index   (port_index),
    .too_short    (too_short),
    .error_count  (error_count),
    .words_due    (words_due),
    .words_checked(words_checked)
  );

  // Receiver: stall each cycle with the current probability
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: count cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte word and hold it until accepted; idle each cycle with the set odds first
  task automatic send_word(input logic [DataW-1:0] value, input logic is_last);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= value;
    last_byte <= is_last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Send a whole packet: random bytes, or every byte the same fill value
  task automatic send_packet(input int len, input int fill);
    int k;
    for (k = 0; k < len; k++) begin
      send_word((fill < 0) ? DataW'($urandom) : DataW'(fill), k == len - 1);
    end
    packets_sent++;
  endtask

  // Drop valid, wait for every predicted word, then let the remainder loop drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leave cfg_write high between back-to-back writes; the caller lowers it
  task automatic set_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CfgW-1:0] offset, input logic [CfgW-1:0] length,
                             input logic [CfgW-1:0] count_word);
    set_reg(REG_WINDOW_OFFSET, offset);
    set_reg(REG_WINDOW_LENGTH, length);
    set_reg(REG_PORT_COUNT, count_word);
    // Junk write to the unused index must leave all three registers alone
    set_reg(REG_UNUSED, CfgW'($urandom));
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int              phase;
    int              span;
    int              plen;
    int              pick;
    int              phase_start;
    int unsigned     cnt;
    logic [CfgW-1:0] off;
    logic [CfgW-1:0] len;
    logic [CfgW-1:0] count_word;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset values: one-byte window at zero, one port
    send_packet(1, 'hA5);

    // Window 2..4 over four ports: short, one short of the end, exact, longer
    settle();
    load_config(2, 3, 4);
    send_packet(1, FILL_RANDOM);
    send_packet(4, FILL_RANDOM);
    send_packet(5, FILL_RANDOM);
    send_packet(7, FILL_RANDOM);

    // Empty window and zero ports
    settle();
    load_config(0, 0, 0);
    send_packet(1, 'h5A);
    send_packet(2, FILL_RANDOM);

    // Empty window past the start: short only below the offset
    settle();
    load_config(3, 0, 8);
    send_packet(2, FILL_RANDOM);
    send_packet(3, FILL_RANDOM);

    // Count word all ones: masked to 511, saturated to the port maximum
    settle();
    load_config(0, 2, 16'hFFFF);
    send_packet(2, 'hFF);
    send_packet(3, FILL_RANDOM);

    settle();
    load_config(0, 4, 2);
    send_packet(4, FILL_RANDOM);

    settle();
    load_config(1, 3, 255);
    send_packet(5, 'hFF);
    send_packet(4, 'h00);

    // Widest window: a packet far short of the window end
    settle();
    load_config(16'hFFFF, 16'hFFFF, 7);
    send_packet(10, FILL_RANDOM);

    // Random phases with small windows so most packets reach the hash
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
        default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
      endcase
      case ($urandom_range(7))
        0: cnt = 2;
        1: cnt = 4;
        2: cnt = 8;
        3: cnt = $urandom_range(1, 256);
        4: cnt = $urandom_range(257, 511);
        5: cnt = $urandom_range(0, 1);
        6: cnt = $urandom_range(255, 256);
        default: cnt = $urandom_range(3, 16);
      endcase
      // Random upper bits in the count word must be ignored
      count_word = CfgW'($urandom);
      count_word[CountW-1:0] = CountW'(cnt);
      off = CfgW'($urandom_range(0, 6));
      len = CfgW'($urandom_range(0, 8));
      load_config(off, len, count_word);
      span = int'(off) + int'(len);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // Mostly packets that reach the window end; some short ones
        pick = $urandom_range(9);
        if (pick < 2) begin
          plen = $urandom_range(1, (span > 1) ? span : 1);
        end else if (pick < 4) begin
          plen = span;
        end else if (pick < 5) begin
          plen = span - 1;
        end else begin
          plen = span + $urandom_range(0, 6);
        end
        if (plen < 1) plen = 1;
        send_packet(plen, ($urandom_range(7) == 0) ? 'hFF : FILL_RANDOM);
      end
    end

    settle();
    $display("Sent %0d packets (%0d byte words) through %0d register settings and four idle mixes.",
             packets_sent, bytes_sent, settings_used);
    $display("Checked %0d port words against the predicted hash.", words_checked);
    if (error_count == 0 && words_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pbshd_pkg.sv
rtl/pbshd_ctrl.sv
rtl/pbshd_dpath.sv
rtl/packet_byte_sum_hash_demux.sv
rtl/pbshd_checker.sv
verif/demux_port_checker.sv
verif/tb_packet_byte_sum_hash_demux.sv
